@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BMFM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BMFM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMFM_ASSERT(lbl, clk, rst_n, prop, msg)
`define BMFM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hw/rtl/bmfm_pkg.sv @@
// shared constants and codes of the bipartite flow matcher
package bmfm_pkg;
    localparam int NODES     = 12;
    localparam int GN        = NODES + 2;
    localparam int GW        = $clog2(GN);
    localparam int EW        = $clog2(NODES);
    localparam int QW        = $clog2(GN + 1);
    localparam int ROW_W     = 2 * GN;
    localparam int MAX_PAIRS = 36;
    localparam int CW        = $clog2(MAX_PAIRS + 1);
    localparam int NODE_W    = 4;
    localparam int FLOW_W    = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFICER_COUNT = 1'b1;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_SOLVE = 1'b1;

    localparam logic KIND_TOTAL = 1'b0;
    localparam logic KIND_PAIR  = 1'b1;
endpackage

@@ hw/rtl/bmfm_resid_ram.sv @@
// residual matrix memory, one row of two-bit entries per graph node
module bmfm_resid_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [bmfm_pkg::GW-1:0]   i_waddr,
    input  logic [bmfm_pkg::ROW_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [bmfm_pkg::GW-1:0]   i_raddr,
    output logic [bmfm_pkg::ROW_W-1:0] o_rdata
);
    import bmfm_pkg::*;

    logic [ROW_W-1:0] mem [GN];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

@@ hw/rtl/bipartite_max_flow_matcher_core.sv @@
// top level of the bipartite maximum flow matcher
// Edge-load beats (func 0) are taken one per cycle while idle and set one
// bit of a flip-flop edge matrix; loads naming a node at or above NODES are
// dropped. A solve beat (func 1) holds the input stalled while one sequencer
// drives a single-port-read residual row memory: it builds the residual
// matrix row by row, then each search dequeues nodes and scans up to
// node_count+2 columns per dequeued node (the scan stops at the sink once a
// path is found), and for each augmenting path edge the parent row is read,
// then its forward and reverse entries are written. The result beats follow:
// the total flow, then each officer-agent pair carrying flow in officer-major
// order, the final beat flagged by last; the pair scan walks each officer row
// and its agent columns and waits when a beat finds the output stalled. The
// output register lets edge loads for the next problem enter while the last
// result beat still waits. The edge matrix is cleared when the last result is issued.
`include "assert_macros.svh"
module bipartite_max_flow_matcher_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [bmfm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bmfm_pkg::CFG_W-1:0]    i_cfg_data,
    // input beats
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [bmfm_pkg::NODE_W-1:0]   i_from_node,
    input  logic [bmfm_pkg::NODE_W-1:0]   i_to_node,
    // result beats
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_kind,
    output logic [bmfm_pkg::FLOW_W-1:0]   o_flow_total,
    output logic [bmfm_pkg::NODE_W-1:0]   o_officer,
    output logic [bmfm_pkg::NODE_W-1:0]   o_agent,
    output logic                          o_last
);
    import bmfm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_BFS_START,
        ST_BFS_DEQ,
        ST_BFS_SCAN,
        ST_AUG_RD_U,
        ST_AUG_WR_U,
        ST_AUG_WR_V,
        ST_PAIR_ROW,
        ST_PAIR_SCAN,
        ST_EMIT_LAST
    } t_state;

    t_state r_state;

    // configuration
    logic [CFG_W-1:0] r_node_count;
    logic [CFG_W-1:0] r_officer_count;

    // edge matrix, node numbering (graph index minus one)
    logic [NODES-1:0] r_edge [NODES];

    // search state
    logic [GW-1:0]    r_n;
    logic [GW-1:0]    r_k;
    logic [GW-1:0]    r_row;
    logic [GN-1:0]    r_visited;
    logic [GW-1:0]    r_parent [GN];
    logic [GW-1:0]    r_queue [GN];
    logic [QW-1:0]    r_head;
    logic [QW-1:0]    r_tail;
    logic [GW-1:0]    r_u;
    logic [GW-1:0]    r_v;
    logic [FLOW_W-1:0] r_flow;

    // pair scan and the result held back until the next one is known
    logic [GW-1:0]    r_i;
    logic [GW-1:0]    r_j;
    logic [CW-1:0]    r_cnt;
    logic             r_hold_kind;
    logic [FLOW_W-1:0] r_hold_flow;
    logic [NODE_W-1:0] r_hold_off;
    logic [NODE_W-1:0] r_hold_ag;

    // output register
    logic             r_out_valid;
    logic             r_kind;
    logic [FLOW_W-1:0] r_flow_total;
    logic [NODE_W-1:0] r_officer;
    logic [NODE_W-1:0] r_agent;
    logic             r_last;

    // residual memory port
    logic             ram_we;
    logic [GW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic             ram_re;
    logic [GW-1:0]    ram_raddr;
    logic [ROW_W-1:0] ram_rdata;

    logic [GW-1:0]    n_clip;
    logic [GW-1:0]    k_clip;
    logic [GW-1:0]    sink;
    logic [GW-1:0]    mod_col;
    logic [1:0]       rcol_v;
    logic [1:0]       rcol_j;
    logic [1:0]       rcol_mod;
    logic             cand;
    logic             out_free;
    logic             out_load;
    logic             pair_hit;
    logic [NODES-1:0] init_edge_row;
    logic [ROW_W-1:0] init_row;
    logic [ROW_W-1:0] mod_row;
    logic [NODES-1:0] pair_edge_row;

    bmfm_resid_ram u_resid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // clip configuration to the store size and the node count
    always_comb begin
        if (r_node_count > CFG_W'(NODES)) begin
            n_clip = GW'(NODES);
        end else begin
            n_clip = r_node_count[GW-1:0];
        end
        if (r_officer_count > CFG_W'(n_clip)) begin
            k_clip = n_clip;
        end else begin
            k_clip = r_officer_count[GW-1:0];
        end
    end

    assign sink     = r_n + GW'(1);
    assign out_free = !r_out_valid || !i_out_stall;
    assign rcol_v   = ram_rdata[{r_v, 1'b0} +: 2];
    assign rcol_j   = ram_rdata[{r_j, 1'b0} +: 2];
    assign cand     = !r_visited[r_v] && (rcol_v != 2'd0);

    // a result beat enters the output register this cycle
    assign out_load = out_free && ((r_state == ST_PAIR_SCAN && pair_hit)
                                   || r_state == ST_EMIT_LAST);

    assign init_edge_row = r_edge[EW'(r_row - GW'(1))];
    assign pair_edge_row = r_edge[EW'(r_i - GW'(1))];
    assign pair_hit      = pair_edge_row[EW'(r_j - GW'(1))] && (rcol_j == 2'd0)
                           && (r_cnt < CW'(MAX_PAIRS));

    // one residual row at build time: source row, node rows, sink and unused rows zero
    always_comb begin
        init_row = '0;
        for (int c = 0; c < GN; c++) begin
            if (r_row == '0) begin
                if (c >= 1 && GW'(c) <= r_k) begin
                    init_row[2*c] = 1'b1;
                end
            end else if (r_row <= r_n) begin
                if (c >= 1 && c <= NODES) begin
                    if (GW'(c) <= r_n) begin
                        init_row[2*c] = init_edge_row[c-1];
                    end
                end
                if (GW'(c) == sink && r_row > r_k) begin
                    init_row[2*c] = 1'b1;
                end
            end
        end
    end

    // path edge update: decrement forward entry, increment reverse entry
    always_comb begin
        if (r_state == ST_AUG_WR_U) begin
            mod_col = r_v;
        end else begin
            mod_col = r_u;
        end
        rcol_mod = ram_rdata[{mod_col, 1'b0} +: 2];
        mod_row  = ram_rdata;
        if (r_state == ST_AUG_WR_U) begin
            mod_row[{mod_col, 1'b0} +: 2] = rcol_mod - 2'd1;
        end else begin
            mod_row[{mod_col, 1'b0} +: 2] = rcol_mod + 2'd1;
        end
    end

    // memory port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_row;
        ram_wdata = init_row;
        ram_re    = 1'b0;
        ram_raddr = r_v;
        case (r_state)
            ST_INIT: begin
                ram_we = 1'b1;
            end
            ST_BFS_DEQ: begin
                ram_re    = (r_head != r_tail);
                ram_raddr = r_queue[r_head[GW-1:0]];
            end
            ST_AUG_RD_U: begin
                ram_re    = 1'b1;
                ram_raddr = r_parent[r_v];
            end
            ST_AUG_WR_U: begin
                ram_we    = 1'b1;
                ram_waddr = r_u;
                ram_wdata = mod_row;
                ram_re    = 1'b1;
                ram_raddr = r_v;
            end
            ST_AUG_WR_V: begin
                ram_we    = 1'b1;
                ram_waddr = r_v;
                ram_wdata = mod_row;
            end
            ST_PAIR_ROW: begin
                ram_re    = 1'b1;
                ram_raddr = r_i;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_node_count    <= CFG_W'(12);
            r_officer_count <= CFG_W'(6);
            r_out_valid     <= 1'b0;
            r_flow          <= '0;
            r_head          <= '0;
            r_tail          <= '0;
            r_visited       <= '0;
            r_k             <= '0;
            for (int e = 0; e < NODES; e++) begin
                r_edge[e] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NODE_COUNT:    r_node_count    <= i_cfg_data;
                    CFG_OFFICER_COUNT: r_officer_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (i_func == FUNC_LOAD) begin
                            if (i_from_node < NODE_W'(NODES) && i_to_node < NODE_W'(NODES)) begin
                                r_edge[EW'(i_from_node)][EW'(i_to_node)] <= 1'b1;
                            end
                        end else begin
                            r_n     <= n_clip;
                            r_k     <= k_clip;
                            r_row   <= '0;
                            r_flow  <= '0;
                            r_state <= ST_INIT;
                        end
                    end
                end
                ST_INIT: begin
                    r_row <= r_row + GW'(1);
                    if (r_row == GW'(GN - 1)) begin
                        r_state <= ST_BFS_START;
                    end
                end
                ST_BFS_START: begin
                    r_visited  <= {{(GN-1){1'b0}}, 1'b1};
                    r_queue[0] <= '0;
                    r_head     <= '0;
                    r_tail     <= QW'(1);
                    r_state    <= ST_BFS_DEQ;
                end
                ST_BFS_DEQ: begin
                    if (r_head == r_tail) begin
                        // no path left: total first, then the pair scan
                        r_hold_kind <= KIND_TOTAL;
                        r_hold_flow <= r_flow;
                        r_hold_off  <= '0;
                        r_hold_ag   <= '0;
                        r_i         <= GW'(1);
                        r_cnt       <= '0;
                        r_state     <= ST_PAIR_ROW;
                    end else begin
                        r_u     <= r_queue[r_head[GW-1:0]];
                        r_head  <= r_head + QW'(1);
                        r_v     <= '0;
                        r_state <= ST_BFS_SCAN;
                    end
                end
                ST_BFS_SCAN: begin
                    if (cand) begin
                        r_parent[r_v] <= r_u;
                    end
                    if (cand && r_v == sink) begin
                        r_state <= ST_AUG_RD_U;
                    end else begin
                        if (cand) begin
                            r_visited[r_v] <= 1'b1;
                            if (r_tail < QW'(GN)) begin
                                r_queue[r_tail[GW-1:0]] <= r_v;
                                r_tail <= r_tail + QW'(1);
                            end
                        end
                        if (r_v == sink) begin
                            r_state <= ST_BFS_DEQ;
                        end else begin
                            r_v <= r_v + GW'(1);
                        end
                    end
                end
                ST_AUG_RD_U: begin
                    r_u     <= r_parent[r_v];
                    r_state <= ST_AUG_WR_U;
                end
                ST_AUG_WR_U: begin
                    r_state <= ST_AUG_WR_V;
                end
                ST_AUG_WR_V: begin
                    r_v <= r_u;
                    if (r_u == '0) begin
                        // every path carries one unit, the source edges have capacity one
                        r_flow  <= r_flow + FLOW_W'(1);
                        r_state <= ST_BFS_START;
                    end else begin
                        r_state <= ST_AUG_RD_U;
                    end
                end
                ST_PAIR_ROW: begin
                    if (r_i > r_k || r_k >= r_n) begin
                        r_state <= ST_EMIT_LAST;
                    end else begin
                        r_j     <= r_k + GW'(1);
                        r_state <= ST_PAIR_SCAN;
                    end
                end
                ST_PAIR_SCAN: begin
                    if (!(pair_hit && !out_free)) begin
                        if (pair_hit) begin
                            r_kind       <= r_hold_kind;
                            r_flow_total <= r_hold_flow;
                            r_officer    <= r_hold_off;
                            r_agent      <= r_hold_ag;
                            r_last       <= 1'b0;
                            r_hold_kind  <= KIND_PAIR;
                            r_hold_flow  <= '0;
                            r_hold_off   <= NODE_W'(r_i - GW'(1));
                            r_hold_ag    <= NODE_W'(r_j - GW'(1));
                            r_cnt        <= r_cnt + CW'(1);
                        end
                        if (r_j == r_n) begin
                            r_i     <= r_i + GW'(1);
                            r_state <= ST_PAIR_ROW;
                        end else begin
                            r_j <= r_j + GW'(1);
                        end
                    end
                end
                ST_EMIT_LAST: begin
                    if (out_free) begin
                        r_kind       <= r_hold_kind;
                        r_flow_total <= r_hold_flow;
                        r_officer    <= r_hold_off;
                        r_agent      <= r_hold_ag;
                        r_last       <= 1'b1;
                        for (int e = 0; e < NODES; e++) begin
                            r_edge[e] <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_flow_total = r_flow_total;
    assign o_officer    = r_officer;
    assign o_agent      = r_agent;
    assign o_last       = r_last;

    // queue pointers never cross
    `BMFM_ASSERT(a_queue_order, i_clk, i_rst_n, (r_head <= r_tail), "queue head passed tail")
    // a path edge always has residual left when it is taken
    `BMFM_ASSERT(a_path_residual, i_clk, i_rst_n, (r_state == ST_AUG_WR_U) |-> (rcol_mod != 2'd0), "augmenting an empty residual entry")
    // flow cannot exceed the number of officers
    `BMFM_ASSERT(a_flow_bound, i_clk, i_rst_n, (r_state != ST_IDLE && r_state != ST_INIT) |-> (GW'(r_flow) <= r_k), "flow above officer count")
endmodule

@@ test/bipartite_max_flow_matcher_core_test.sv @@
// testbench for the bipartite maximum flow matcher core
module bipartite_max_flow_matcher_core_test;
    import bmfm_pkg::*;

    // one result beat of a solve
    typedef struct {
        logic              kind;
        logic [FLOW_W-1:0] flow;
        logic [NODE_W-1:0] officer;
        logic [NODE_W-1:0] agent;
        logic              last;
    } t_match_beat;

    typedef enum logic [1:0] {ROW_LOAD, ROW_SOLVE, ROW_CFG} t_row_op;

    typedef struct {
        t_row_op op;
        int      a;        // from node, or register index
        int      b;        // to node, or register data
        int      flow;     // typed total flow of an empty solve, -1 to predict
    } t_stim_row;

    localparam int LIMIT      = 600000;
    localparam int DRAIN_WAIT = 40;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_NODE_COUNT;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_func = FUNC_LOAD;
    logic [NODE_W-1:0] i_from_node = '0;
    logic [NODE_W-1:0] i_to_node = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_kind;
    logic [FLOW_W-1:0] o_flow_total;
    logic [NODE_W-1:0] o_officer;
    logic [NODE_W-1:0] o_agent;
    logic              o_last;

    // predictor state, flow numbering: node x is index x+1, source 0
    bit  edge_bits [GN][GN];
    int  resid [GN][GN];
    int  link [GN];
    bit  seen [GN];
    int  node_cnt = 12;
    int  officer_cnt = 6;

    t_match_beat pending_beats[$];
    int  errors = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;

    t_stim_row directed[] = '{
        '{ROW_SOLVE, 0, 0, 0},                  // empty store after reset
        '{ROW_LOAD, 15, 15, -1},                // out of store, dropped
        '{ROW_LOAD, 12, 0, -1},
        '{ROW_LOAD, 0, 12, -1},
        '{ROW_LOAD, 0, 11, -1},
        '{ROW_LOAD, 5, 6, -1},
        '{ROW_LOAD, 5, 5, -1},                  // self loop
        '{ROW_LOAD, 6, 0, -1},                  // agent back to officer
        '{ROW_LOAD, 1, 6, -1},
        '{ROW_LOAD, 0, 6, -1},
        '{ROW_SOLVE, 0, 0, -1},
        '{ROW_CFG, CFG_NODE_COUNT, 0, -1},      // zero nodes
        '{ROW_LOAD, 0, 6, -1},
        '{ROW_SOLVE, 0, 0, 0},
        '{ROW_CFG, CFG_NODE_COUNT, 15, -1},     // above NODES
        '{ROW_CFG, CFG_OFFICER_COUNT, 15, -1},  // every node an officer
        '{ROW_LOAD, 0, 1, -1},
        '{ROW_SOLVE, 0, 0, 0},
        '{ROW_CFG, CFG_OFFICER_COUNT, 0, -1},   // no officers
        '{ROW_LOAD, 3, 4, -1},
        '{ROW_SOLVE, 0, 0, 0},
        '{ROW_CFG, CFG_NODE_COUNT, 1, -1},
        '{ROW_CFG, CFG_OFFICER_COUNT, 1, -1},
        '{ROW_SOLVE, 0, 0, 0}
    };

    bipartite_max_flow_matcher_core u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall, changed on the falling edge
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_match_beat w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_beats.size() == 0) begin
                report("unexpected beat, kind", o_kind, 0);
            end else begin
                w = pending_beats.pop_front();
                if (o_kind !== w.kind) report("kind", o_kind, w.kind);
                if (o_flow_total !== w.flow) report("flow_total", o_flow_total, w.flow);
                if (o_officer !== w.officer) report("officer", o_officer, w.officer);
                if (o_agent !== w.agent) report("agent", o_agent, w.agent);
                if (o_last !== w.last) report("last", o_last, w.last);
            end
        end
    end

    // breadth-first search from the source, ascending neighbor order
    function automatic bit find_route(int g, int sink);
        int q[$];
        int u;
        foreach (seen[v]) seen[v] = 0;
        q.push_back(0);
        seen[0] = 1;
        while (q.size() > 0) begin
            u = q.pop_front();
            for (int v = 0; v < g; v++) begin
                if (!seen[v] && resid[u][v] > 0) begin
                    link[v] = u;
                    if (v == sink) return 1;
                    seen[v] = 1;
                    q.push_back(v);
                end
            end
        end
        return 0;
    endfunction

    // max flow matching of the loaded edges, appends the result beats
    function automatic void solve_matching(ref t_match_beat beats[$]);
        int n, k, g, sink, pf, v, u, steps, total;
        t_match_beat b;
        n = (node_cnt > NODES) ? NODES : node_cnt;
        k = (officer_cnt > n) ? n : officer_cnt;
        g = n + 2;
        sink = n + 1;
        foreach (resid[i, j]) resid[i][j] = 0;
        for (int i = 1; i <= n; i++) begin
            if (i <= k) resid[0][i] = 1;
            else resid[i][sink] = 1;
            for (int j = 1; j <= n; j++) resid[i][j] = edge_bits[i][j];
        end
        total = 0;
        while (find_route(g, sink)) begin
            pf = 3;
            v = sink;
            for (steps = 0; v != 0 && steps < g; steps++) begin
                u = link[v];
                if (resid[u][v] < pf) pf = resid[u][v];
                v = u;
            end
            v = sink;
            for (steps = 0; v != 0 && steps < g; steps++) begin
                u = link[v];
                resid[u][v] = (resid[u][v] - pf) & 255;
                resid[v][u] = (resid[v][u] + pf) & 255;
                v = u;
            end
            total = (total + pf) & 7;
        end
        b = '{KIND_TOTAL, FLOW_W'(total), '0, '0, 1'b0};
        beats.push_back(b);
        for (int i = 1; i <= k; i++)
            for (int j = k + 1; j <= n; j++)
                if (edge_bits[i][j] && resid[i][j] < edge_bits[i][j]) begin
                    b = '{KIND_PAIR, '0, NODE_W'(i - 1), NODE_W'(j - 1), 1'b0};
                    beats.push_back(b);
                end
        beats[beats.size() - 1].last = 1;
        foreach (edge_bits[i, j]) edge_bits[i][j] = 0;
    endfunction

    // drive one input beat, update the prediction on acceptance
    task automatic send_beat(logic func, int a, int b, int typed_flow);
        t_match_beat beats[$];
        t_match_beat t;
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_func = func;
        i_from_node = NODE_W'(a);
        i_to_node = NODE_W'(b);
        do @(posedge i_clk); while (o_in_stall);
        if (func == FUNC_LOAD) begin
            if (a < NODES && b < NODES) edge_bits[a + 1][b + 1] = 1;
        end else begin
            solve_matching(beats);
            if (typed_flow >= 0) begin
                t = '{KIND_TOTAL, FLOW_W'(typed_flow), '0, '0, 1'b1};
                pending_beats.push_back(t);
            end else begin
                foreach (beats[i]) pending_beats.push_back(beats[i]);
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // register write, only once the block has gone quiet
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = CFG_W'(data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_NODE_COUNT) node_cnt = data;
        else officer_cnt = data;
    endtask

    initial begin
        int n, k, loads, a, b;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed[r]) begin
            case (directed[r].op)
                ROW_LOAD:  send_beat(FUNC_LOAD, directed[r].a, directed[r].b, -1);
                ROW_SOLVE: send_beat(FUNC_SOLVE, 0, 0, directed[r].flow);
                default:   write_reg(CFG_IDX_W'(directed[r].a), directed[r].b);
            endcase
        end

        // idle phases: none, sender heavy, receiver heavy, both
        for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct = (mode == 1) ? 88 : (mode == 3) ? 36 : 0;
            stall_pct     = (mode == 2) ? 88 : (mode == 3) ? 36 : 0;
            for (int p = 0; p < 7; p++) begin
                if (p == 0 || $urandom_range(2) == 0) begin
                    n = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(2, 12);
                    k = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n / 2 + 1);
                    write_reg(CFG_NODE_COUNT, n);
                    write_reg(CFG_OFFICER_COUNT, k);
                end
                n = (node_cnt > NODES) ? NODES : node_cnt;
                k = (officer_cnt > n) ? n : officer_cnt;
                loads = $urandom_range(1, 10);
                repeat (loads) begin
                    if (k > 0 && n > k && $urandom_range(9) < 8) begin
                        a = $urandom_range(k - 1);
                        b = $urandom_range(n - 1, k);
                    end else begin
                        a = $urandom_range(15);
                        b = $urandom_range(15);
                    end
                    send_beat(FUNC_LOAD, a, b, -1);
                end
                send_beat(FUNC_SOLVE, $urandom_range(15), $urandom_range(15), -1);
            end
        end

        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
